@@ sv/tbspeq_pkg.sv @@
// tbspeq_pkg: constants, payload and control types, and the coefficient rom
// for the three-band equalizer; no dependencies
package tbspeq_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int TABLE_INTERVALS = 128;
  localparam int STAGE_COUNT     = 3;
  localparam int SAMPLE_RATE_HZ  = 48000;

  localparam int BAND_COUNT  = STAGE_COUNT;
  localparam int LANE_COUNT  = 2;
  localparam int COEF_COUNT  = 5;
  localparam int TAP_COUNT   = 4;
  localparam int COEF_W      = 32;
  localparam int FRAC_BITS   = 27;
  localparam int GAIN_W      = 14;
  localparam int GAIN_MIN    = -5120;
  localparam int GAIN_MAX    = 768;
  localparam int GAIN_SPAN   = GAIN_MAX - GAIN_MIN;
  localparam int DB_SPAN     = 92;
  localparam int DB_FLOOR    = 80;
  localparam int REG_COUNT   = 4;
  localparam int CFG_IDX_W   = $clog2(REG_COUNT);
  localparam int CFG_DATA_W  = GAIN_W;

  localparam int ROM_DEPTH   = TABLE_INTERVALS + 1;
  localparam int ROM_ENTRIES = BAND_COUNT * ROM_DEPTH;
  localparam int ADDR_W      = $clog2(ROM_ENTRIES);
  localparam int IDX_W       = $clog2(ROM_DEPTH);
  localparam int R_W         = $clog2(GAIN_SPAN);
  localparam int OFFS_W      = $clog2(GAIN_SPAN + 1);
  localparam int Q_W         = $clog2(GAIN_SPAN * TABLE_INTERVALS + 1);
  localparam int IPROD_W     = COEF_W + 1 + R_W + 1;
  localparam int DIV_W       = IPROD_W - 1;
  localparam int DCNT_W      = $clog2(DIV_W + 1);
  localparam int STG_W       = $clog2(STAGE_COUNT);
  localparam int TAP_W       = $clog2(COEF_COUNT);
  localparam int PROD_W      = COEF_W + SAMPLE_BITS;
  localparam int ACC_W       = PROD_W + 3;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = CFG_IDX_W'(3);

  localparam logic [TAP_W-1:0] TAP_X0 = TAP_W'(0);
  localparam logic [TAP_W-1:0] TAP_X1 = TAP_W'(1);
  localparam logic [TAP_W-1:0] TAP_X2 = TAP_W'(2);
  localparam logic [TAP_W-1:0] TAP_Y1 = TAP_W'(3);
  localparam logic [TAP_W-1:0] TAP_Y2 = TAP_W'(4);

  localparam logic DIV_SRC_GAIN = 1'b0;
  localparam logic DIV_SRC_PROD = 1'b1;

  localparam longint QONE          = 64'sd4294967296;
  localparam longint LN10_Q32      = 64'sd9889527671;
  localparam longint TWO_PI_Q32    = 64'sd26986075410;
  localparam longint SQRT_HALF_Q32 = 64'sd3037000500;
  localparam longint FREQ_LOW_HZ   = 64'sd300;
  localparam longint FREQ_MID_HZ   = 64'sd1000;
  localparam longint FREQ_HIGH_HZ  = 64'sd4000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_item_t;

  typedef struct packed {
    logic             in_load;
    logic             mul_en;
    logic             acc_clr;
    logic             stage_end;
    logic             out_load;
    logic             div_start;
    logic             div_src;
    logic             idx_load;
    logic             rom_rd;
    logic             rom_hi;
    logic             lo_load;
    logic             imul;
    logic             coef_store;
    logic [STG_W-1:0] sel_band;
    logic [TAP_W-1:0] sel_tap;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
    logic div_busy;
  } dp_status_t;

  typedef logic [COEF_COUNT-1:0][COEF_W-1:0] coef_set_t;
  typedef logic [ROM_ENTRIES-1:0][COEF_COUNT-1:0][COEF_W-1:0] coef_rom_t;

  // elaboration-time helpers for the rom build
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint sdiv(input longint num, input longint den);
    logic        neg;
    logic [63:0] un;
    logic [63:0] ud;
    logic [63:0] uq;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? 64'(-num) : 64'(num);
    ud  = (den < 0) ? 64'(-den) : 64'(den);
    uq  = udiv64(un, ud);
    return neg ? -$signed(uq) : $signed(uq);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    logic [63:0]  r;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? 64'(-a) : 64'(a);
    ub  = (b < 0) ? 64'(-b) : 64'(b);
    p   = {64'd0, ua} * {64'd0, ub};
    r   = {1'b0, p[94:32]};
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic longint qexp(input longint x);
    longint y;
    longint sum;
    longint term;
    y    = x / 256;
    sum  = QONE;
    term = QONE;
    for (longint n = 1; n <= 8; n++) begin
      term = sdiv(qmul(term, y), n);
      sum  = sum + term;
    end
    for (int n = 0; n < 8; n++) begin
      sum = qmul(sum, sum);
    end
    return sum;
  endfunction

  function automatic longint qcos(input longint w);
    longint x2;
    longint tc;
    longint sc;
    x2 = qmul(w, w);
    tc = QONE;
    sc = QONE;
    for (longint k = 1; k <= 15; k++) begin
      tc = -sdiv(qmul(tc, x2), (2 * k - 1) * (2 * k));
      sc = sc + tc;
    end
    return sc;
  endfunction

  function automatic longint qsin(input longint w);
    longint x2;
    longint ts;
    longint ss;
    x2 = qmul(w, w);
    ts = w;
    ss = w;
    for (longint k = 1; k <= 15; k++) begin
      ts = -sdiv(qmul(ts, x2), (2 * k) * (2 * k + 1));
      ss = ss + ts;
    end
    return ss;
  endfunction

  function automatic logic [COEF_W-1:0] div27(input longint num, input longint den);
    logic              neg;
    logic [63:0]       un;
    logic [63:0]       ud;
    logic [63:0]       uq;
    logic [COEF_W-1:0] res;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? 64'(-num) : 64'(num);
    ud  = (den < 0) ? 64'(-den) : 64'(den);
    if (un > (64'd1 << 36)) begin
      un = 64'd1 << 36;
    end
    if (den == 0) begin
      res = '0;
    end else begin
      uq = udiv64((un << 27) + (ud >> 1), ud);
      if (neg) begin
        res = (uq > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - uq);
      end else begin
        res = (uq > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : uq[COEF_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic coef_set_t store5(input longint b0, input longint b1, input longint b2,
                                       input longint a0, input longint a1, input longint a2);
    coef_set_t s;
    s[0] = div27(b0, a0);
    s[1] = div27(b1, a0);
    s[2] = div27(b2, a0);
    s[3] = div27(-a1, a0);
    s[4] = div27(-a2, a0);
    return s;
  endfunction

  function automatic coef_rom_t build_rom();
    coef_rom_t rom;
    longint    cs0, sn0, cs1, sn1, cs2, sn2;
    longint    db, x, ea, ra, ia, ap1, am1, al, tra, mc, pc, aa, aia;
    cs0 = qcos(TWO_PI_Q32 * FREQ_LOW_HZ / SAMPLE_RATE_HZ);
    sn0 = qsin(TWO_PI_Q32 * FREQ_LOW_HZ / SAMPLE_RATE_HZ);
    cs1 = qcos(TWO_PI_Q32 * FREQ_MID_HZ / SAMPLE_RATE_HZ);
    sn1 = qsin(TWO_PI_Q32 * FREQ_MID_HZ / SAMPLE_RATE_HZ);
    cs2 = qcos(TWO_PI_Q32 * FREQ_HIGH_HZ / SAMPLE_RATE_HZ);
    sn2 = qsin(TWO_PI_Q32 * FREQ_HIGH_HZ / SAMPLE_RATE_HZ);
    for (int i = 0; i < ROM_DEPTH; i++) begin
      db  = (longint'(DB_SPAN * i - DB_FLOOR * TABLE_INTERVALS) * QONE) / TABLE_INTERVALS;
      x   = qmul(db, LN10_Q32) / 40;
      ea  = qexp(x);
      ra  = qexp(x / 2);
      ia  = qexp(-x);
      ap1 = ea + QONE;
      am1 = ea - QONE;
      // low shelf
      al  = qmul(sn0, SQRT_HALF_Q32);
      tra = 2 * qmul(ra, al);
      mc  = qmul(am1, cs0);
      pc  = qmul(ap1, cs0);
      rom[i] = store5(qmul(ea, ap1 - mc + tra), 2 * qmul(ea, am1 - pc),
                      qmul(ea, ap1 - mc - tra), ap1 + mc + tra, -2 * (am1 + pc),
                      ap1 + mc - tra);
      // peak
      al  = (sn1 * 5) / 8;
      aa  = qmul(al, ea);
      aia = qmul(al, ia);
      rom[ROM_DEPTH + i] = store5(QONE + aa, -2 * cs1, QONE - aa, QONE + aia, -2 * cs1,
                                  QONE - aia);
      // high shelf
      al  = qmul(sn2, SQRT_HALF_Q32);
      tra = 2 * qmul(ra, al);
      mc  = qmul(am1, cs2);
      pc  = qmul(ap1, cs2);
      rom[2 * ROM_DEPTH + i] = store5(qmul(ea, ap1 + mc + tra), -2 * qmul(ea, am1 + pc),
                                      qmul(ea, ap1 + mc - tra), ap1 - mc + tra,
                                      2 * (am1 - pc), ap1 - mc - tra);
    end
    return rom;
  endfunction

  localparam coef_rom_t COEF_ROM = build_rom();

endpackage

@@ sv/tbspeq_div.sv @@
// tbspeq_div: divider by the gain span, a shift by 256 then one byte a cycle against 23
// by reciprocal multiplication; depends on tbspeq_pkg
module tbspeq_div import tbspeq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output logic             busy,
  output logic [DIV_W-1:0] quot,
  output logic [R_W-1:0]   rem
);

  localparam int LOW_W   = 8;
  localparam int ODD_DIV = GAIN_SPAN >> LOW_W;
  localparam int DIGIT_W = 8;
  localparam int NUM_W   = DIV_W - LOW_W;
  localparam int DIGITS  = (NUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int WORK_W  = DIGITS * DIGIT_W;
  localparam int PART_W  = R_W - LOW_W;
  localparam int T_W     = PART_W + DIGIT_W;
  localparam int RCP_SH  = 17;
  localparam int RCP_W   = 13;
  localparam int MUL_W   = T_W + RCP_W;

  localparam logic [RCP_W-1:0] RECIP   = RCP_W'(((1 << RCP_SH) + ODD_DIV - 1) / ODD_DIV);
  localparam logic [T_W-1:0]   DIVISOR = T_W'(ODD_DIV);

  logic [DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORK_W-1:0]  num_r, num_nxt;
  logic [WORK_W-1:0]  quot_r, quot_nxt;
  logic [PART_W-1:0]  part_r, part_nxt;
  logic [LOW_W-1:0]   low_r, low_nxt;
  logic [T_W-1:0]     t;
  logic [MUL_W-1:0]   mul;
  logic [DIGIT_W-1:0] digit;
  logic [T_W-1:0]     rem_t;

  always_comb begin
    t        = {part_r, num_r[WORK_W-1 -: DIGIT_W]};
    mul      = MUL_W'(t) * MUL_W'(RECIP);
    digit    = DIGIT_W'(mul >> RCP_SH);
    rem_t    = t - T_W'(digit) * DIVISOR;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quot_nxt = quot_r;
    part_nxt = part_r;
    low_nxt  = low_r;
    if (start) begin
      cnt_nxt  = DCNT_W'(DIGITS);
      num_nxt  = WORK_W'(dividend[DIV_W-1:LOW_W]);
      quot_nxt = '0;
      part_nxt = '0;
      low_nxt  = dividend[LOW_W-1:0];
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      num_nxt  = {num_r[WORK_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      quot_nxt = {quot_r[WORK_W-DIGIT_W-1:0], digit};
      part_nxt = PART_W'(rem_t);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    part_r <= part_nxt;
    low_r  <= low_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quot = DIV_W'(quot_r);
  assign rem  = {part_r, low_r};

endmodule

@@ sv/tbspeq_dp.sv @@
// tbspeq_dp: datapath with gain registers, coefficient rom and interpolation, per-channel
// multiply-accumulates sharing a coefficient, filter history; uses tbspeq_pkg, tbspeq_div
module tbspeq_dp import tbspeq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_data,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  localparam logic signed [GAIN_W-1:0] GAIN_LO = GAIN_W'(GAIN_MIN);
  localparam logic signed [GAIN_W-1:0] GAIN_HI = GAIN_W'(GAIN_MAX);
  localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

  logic signed [GAIN_W-1:0]      gain_r [BAND_COUNT];
  logic                          bypass_r;
  logic signed [SAMPLE_BITS-1:0] x_r [LANE_COUNT];
  logic signed [SAMPLE_BITS-1:0] hist_r [LANE_COUNT][STAGE_COUNT][TAP_COUNT];
  logic signed [PROD_W-1:0]      prod_r [LANE_COUNT];
  logic signed [ACC_W-1:0]       acc_r [LANE_COUNT];
  logic                          prod_vld_r;
  logic [COEF_W-1:0]             coeff_r [BAND_COUNT][COEF_COUNT];
  logic [IDX_W-1:0]              idx_r;
  logic [R_W-1:0]                frac_r;
  coef_set_t                     rom_q_r;
  coef_set_t                     lo_r;
  logic signed [IPROD_W-1:0]     iprod_r;
  logic                          div_neg_r;
  out_item_t                     out_r;

  logic signed [SAMPLE_BITS-1:0] in_lane [LANE_COUNT];
  logic signed [SAMPLE_BITS-1:0] operand [LANE_COUNT];
  logic signed [SAMPLE_BITS-1:0] y_sat [LANE_COUNT];
  logic signed [ACC_W-1:0]       rnd [LANE_COUNT];
  logic signed [ACC_W-1:0]       shf [LANE_COUNT];
  logic signed [COEF_W-1:0]      coef_sel;
  logic signed [GAIN_W-1:0]      gsel, gclamp;
  logic [OFFS_W-1:0]             offs;
  logic [Q_W-1:0]                qval;
  logic [IDX_W-1:0]              rd_idx;
  logic [ADDR_W-1:0]             rom_addr;
  logic signed [COEF_W:0]        diff;
  logic [IPROD_W-1:0]            imag;
  logic [DIV_W-1:0]              dividend;
  logic                          div_busy;
  logic [DIV_W-1:0]              quot;
  logic [R_W-1:0]                rem;
  logic [COEF_W-1:0]             quot_s;

  assign in_lane[0] = in_data.left_sample;
  assign in_lane[1] = in_data.right_sample;

  always_comb begin
    coef_sel = $signed(coeff_r[cmd.sel_band][cmd.sel_tap]);
    for (int l = 0; l < LANE_COUNT; l++) begin
      case (cmd.sel_tap)
        TAP_X0:  operand[l] = x_r[l];
        TAP_X1:  operand[l] = hist_r[l][cmd.sel_band][0];
        TAP_X2:  operand[l] = hist_r[l][cmd.sel_band][1];
        TAP_Y1:  operand[l] = hist_r[l][cmd.sel_band][2];
        TAP_Y2:  operand[l] = hist_r[l][cmd.sel_band][3];
        default: operand[l] = x_r[l];
      endcase
      rnd[l] = acc_r[l] + ROUND_HALF;
      shf[l] = rnd[l] >>> FRAC_BITS;
      if ((&shf[l][ACC_W-1:SAMPLE_BITS-1]) || !(|shf[l][ACC_W-1:SAMPLE_BITS-1])) begin
        y_sat[l] = shf[l][SAMPLE_BITS-1:0];
      end else begin
        y_sat[l] = {shf[l][ACC_W-1], {(SAMPLE_BITS - 1){~shf[l][ACC_W-1]}}};
      end
    end
  end

  // gain to table position
  always_comb begin
    gsel = gain_r[cmd.sel_band];
    if (gsel < GAIN_LO) begin
      gclamp = GAIN_LO;
    end else if (gsel > GAIN_HI) begin
      gclamp = GAIN_HI;
    end else begin
      gclamp = gsel;
    end
    offs = OFFS_W'({gclamp[GAIN_W-1], gclamp} - {GAIN_LO[GAIN_W-1], GAIN_LO});
    qval = Q_W'({{(Q_W - OFFS_W){1'b0}}, offs} * Q_W'(TABLE_INTERVALS));
    if (cmd.rom_hi && (idx_r != IDX_W'(TABLE_INTERVALS))) begin
      rd_idx = idx_r + 1'b1;
    end else begin
      rd_idx = idx_r;
    end
    rom_addr = ADDR_W'(ADDR_W'(cmd.sel_band) * ADDR_W'(ROM_DEPTH)) + ADDR_W'(rd_idx);
    diff = $signed({rom_q_r[cmd.sel_tap][COEF_W-1], rom_q_r[cmd.sel_tap]})
         - $signed({lo_r[cmd.sel_tap][COEF_W-1], lo_r[cmd.sel_tap]});
    imag = iprod_r[IPROD_W-1] ? IPROD_W'(-iprod_r) : IPROD_W'(iprod_r);
    if (cmd.div_src == DIV_SRC_PROD) begin
      dividend = imag[DIV_W-1:0];
    end else begin
      dividend = DIV_W'(qval);
    end
    quot_s = div_neg_r ? COEF_W'(-quot[COEF_W-1:0]) : quot[COEF_W-1:0];
  end

  tbspeq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BAND_COUNT; b++) begin
        gain_r[b] <= '0;
      end
      bypass_r   <= 1'b0;
      prod_vld_r <= 1'b0;
      for (int l = 0; l < LANE_COUNT; l++) begin
        for (int s = 0; s < STAGE_COUNT; s++) begin
          for (int t = 0; t < TAP_COUNT; t++) begin
            hist_r[l][s][t] <= '0;
          end
        end
      end
    end else begin
      prod_vld_r <= cmd.mul_en;
      if (cfg_we) begin
        case (cfg_index)
          REG_LOW_GAIN, REG_MID_GAIN, REG_HIGH_GAIN: begin
            gain_r[STG_W'(cfg_index)] <= $signed(cfg_data);
          end
          REG_BYPASS: begin
            bypass_r <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.stage_end) begin
        for (int l = 0; l < LANE_COUNT; l++) begin
          hist_r[l][cmd.sel_band][1] <= hist_r[l][cmd.sel_band][0];
          hist_r[l][cmd.sel_band][0] <= x_r[l];
          hist_r[l][cmd.sel_band][3] <= hist_r[l][cmd.sel_band][2];
          hist_r[l][cmd.sel_band][2] <= y_sat[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANE_COUNT; l++) begin
      if (cmd.in_load) begin
        x_r[l] <= in_lane[l];
      end else if (cmd.stage_end) begin
        x_r[l] <= y_sat[l];
      end
      if (cmd.mul_en) begin
        prod_r[l] <= coef_sel * operand[l];
      end
      if (cmd.acc_clr) begin
        acc_r[l] <= '0;
      end else if (prod_vld_r) begin
        acc_r[l] <= acc_r[l] + ACC_W'(prod_r[l]);
      end
    end
    if (cmd.idx_load) begin
      idx_r  <= quot[IDX_W-1:0];
      frac_r <= rem;
    end
    if (cmd.rom_rd) begin
      rom_q_r <= COEF_ROM[rom_addr];
    end
    if (cmd.lo_load) begin
      lo_r <= rom_q_r;
    end
    if (cmd.imul) begin
      iprod_r <= diff * $signed({1'b0, frac_r});
    end
    if (cmd.div_start) begin
      div_neg_r <= (cmd.div_src == DIV_SRC_PROD) && iprod_r[IPROD_W-1];
    end
    if (cmd.coef_store) begin
      coeff_r[cmd.sel_band][cmd.sel_tap] <= lo_r[cmd.sel_tap] + quot_s;
    end
    if (cmd.out_load) begin
      out_r.left_out  <= x_r[0];
      out_r.right_out <= x_r[1];
    end
  end

  assign out_data        = out_r;
  assign status.bypass   = bypass_r;
  assign status.div_busy = div_busy;

endmodule

@@ sv/tbspeq_ctrl.sv @@
// tbspeq_ctrl: sequencer for coefficient reloads and the per-sample filter pass
// depends on tbspeq_pkg
module tbspeq_ctrl import tbspeq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  dp_status_t           status,
  output dp_cmd_t              cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LQ   = 4'd1;
  localparam logic [3:0] S_LQW  = 4'd2;
  localparam logic [3:0] S_LRLO = 4'd3;
  localparam logic [3:0] S_LRHI = 4'd4;
  localparam logic [3:0] S_LMUL = 4'd5;
  localparam logic [3:0] S_LDIV = 4'd6;
  localparam logic [3:0] S_LDW  = 4'd7;
  localparam logic [3:0] S_LST  = 4'd8;
  localparam logic [3:0] S_FMAC = 4'd9;
  localparam logic [3:0] S_FADD = 4'd10;
  localparam logic [3:0] S_FEND = 4'd11;
  localparam logic [3:0] S_FOUT = 4'd12;

  logic [3:0]            state_r, state_nxt;
  logic [BAND_COUNT-1:0] pend_r, pend_nxt, pend_set, pend_clr;
  logic [STG_W-1:0]      band_r, band_nxt, stage_r, stage_nxt, pick;
  logic [TAP_W-1:0]      k_r, k_nxt, tap_r, tap_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_comb begin
    pend_set = '0;
    if (cfg_we) begin
      case (cfg_index)
        REG_LOW_GAIN, REG_MID_GAIN, REG_HIGH_GAIN: pend_set[STG_W'(cfg_index)] = 1'b1;
        default: pend_set = '0;
      endcase
    end
    pick = '0;
    for (int b = BAND_COUNT - 1; b >= 0; b--) begin
      if (pend_r[b]) begin
        pick = STG_W'(b);
      end
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    band_nxt  = band_r;
    stage_nxt = stage_r;
    k_nxt     = k_r;
    tap_nxt   = tap_r;
    pend_clr  = '0;
    in_ready  = (state_r == S_IDLE) && (pend_r == '0);
    case (state_r)
      S_IDLE: begin
        if (pend_r != '0) begin
          band_nxt       = pick;
          pend_clr[pick] = 1'b1;
          state_nxt      = S_LQ;
        end else if (in_valid) begin
          cmd.in_load = 1'b1;
          stage_nxt   = '0;
          tap_nxt     = '0;
          state_nxt   = status.bypass ? S_FOUT : S_FMAC;
        end
      end
      S_LQ: begin
        cmd.sel_band  = band_r;
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_SRC_GAIN;
        state_nxt     = S_LQW;
      end
      S_LQW: begin
        if (!status.div_busy) begin
          cmd.idx_load = 1'b1;
          state_nxt    = S_LRLO;
        end
      end
      S_LRLO: begin
        cmd.sel_band = band_r;
        cmd.rom_rd   = 1'b1;
        state_nxt    = S_LRHI;
      end
      S_LRHI: begin
        cmd.sel_band = band_r;
        cmd.rom_rd   = 1'b1;
        cmd.rom_hi   = 1'b1;
        cmd.lo_load  = 1'b1;
        k_nxt        = '0;
        state_nxt    = S_LMUL;
      end
      S_LMUL: begin
        cmd.sel_tap = k_r;
        cmd.imul    = 1'b1;
        state_nxt   = S_LDIV;
      end
      S_LDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_SRC_PROD;
        state_nxt     = S_LDW;
      end
      S_LDW: begin
        cmd.div_src = DIV_SRC_PROD;
        if (!status.div_busy) begin
          state_nxt = S_LST;
        end
      end
      S_LST: begin
        cmd.sel_band   = band_r;
        cmd.sel_tap    = k_r;
        cmd.coef_store = 1'b1;
        if (k_r == TAP_W'(COEF_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_LMUL;
        end
      end
      S_FMAC: begin
        cmd.sel_band = stage_r;
        cmd.sel_tap  = tap_r;
        cmd.mul_en   = 1'b1;
        cmd.acc_clr  = (tap_r == TAP_X0);
        if (tap_r == TAP_W'(COEF_COUNT - 1)) begin
          state_nxt = S_FADD;
        end else begin
          tap_nxt = tap_r + 1'b1;
        end
      end
      S_FADD: begin
        state_nxt = S_FEND;
      end
      S_FEND: begin
        cmd.sel_band  = stage_r;
        cmd.stage_end = 1'b1;
        if (stage_r == STG_W'(STAGE_COUNT - 1)) begin
          state_nxt = S_FOUT;
        end else begin
          stage_nxt = stage_r + 1'b1;
          tap_nxt   = '0;
          state_nxt = S_FMAC;
        end
      end
      S_FOUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    pend_nxt = (pend_r & ~pend_clr) | pend_set;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= '1;
      band_r      <= '0;
      stage_r     <= '0;
      k_r         <= '0;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      band_r      <= band_nxt;
      stage_r     <= stage_nxt;
      k_r         <= k_nxt;
      tap_r       <= tap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ sv/three_band_shelf_peak_equalizer.sv @@
// Stereo three-band equalizer: each channel passes a 300 Hz low shelf, a 1 kHz peak
// and a 4 kHz high shelf (direct-form-I biquads, Q4.27 coefficients), output saturated
// to 24 bits. Both channels share one coefficient per cycle on a pair of multipliers;
// a filtered pair passes three stages of five products, a pipeline add and a rounding
// step each, a bypassed pair skips the filter stages, and a finished pair waits in an
// output register while the next pair is taken. A gain write reloads that band's five
// coefficients by interpolating between two rom entries through a divider by the gain
// span; no sample transfer is accepted while a reload runs, and after reset all three
// bands reload the same way. Depends on tbspeq_pkg, tbspeq_ctrl and tbspeq_dp.
module three_band_shelf_peak_equalizer import tbspeq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tbspeq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .status    (status),
    .cmd       (cmd)
  );

  tbspeq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

@@ tb/sv/three_band_shelf_peak_equalizer_test.sv @@
// three_band_shelf_peak_equalizer_test: self-checking bench for the stereo three-band
// equalizer, with its own coefficient table build, interpolation and biquad cascade
// predicting every output pair; depends on tbspeq_pkg and the equalizer top level
module three_band_shelf_peak_equalizer_test import tbspeq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q32   = 64'sd4294967296;
  localparam longint LN10_Q    = 64'sd9889527671;
  localparam longint TWOPI_Q   = 64'sd26986075410;
  localparam longint RSQRT2_Q  = 64'sd3037000500;
  localparam int     NSTEPS    = 128;
  localparam int     SPAN      = 5888;
  localparam int     CYCLE_CAP = 1000000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  three_band_shelf_peak_equalizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // equalizer model state
  int  band_table [3][NSTEPS+1][5];
  int  band_coef [3][5];
  int  biquad_mem [2][3][4];
  int  band_gain [3];
  bit  pass_through;

  in_item_t  sample_q [$];
  out_item_t filtered_q [$];
  int        err_count;
  int        cycle_count;
  int        send_gap;
  int        recv_stall;
  bit        quiet;
  bit        hold_send;
  in_item_t  next_pair;

  function automatic longint fx_mul(input longint a, input longint b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    longint       r;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    p  = {64'd0, ua} * {64'd0, ub};
    r  = longint'({1'b0, p[94:32]});
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint fx_exp(input longint x);
    longint y;
    longint acc;
    longint term;
    y    = x / 256;
    acc  = ONE_Q32;
    term = ONE_Q32;
    for (longint n = 1; n <= 8; n++) begin
      term = fx_mul(term, y) / n;
      acc  = acc + term;
    end
    for (int n = 0; n < 8; n++) acc = fx_mul(acc, acc);
    return acc;
  endfunction

  function automatic void fx_trig(input longint w, output longint c, output longint s);
    longint x2;
    longint tc;
    longint ts;
    x2 = fx_mul(w, w);
    tc = ONE_Q32;
    c  = ONE_Q32;
    ts = w;
    s  = w;
    for (longint k = 1; k <= 15; k++) begin
      tc = -(fx_mul(tc, x2) / ((2 * k - 1) * (2 * k)));
      c  = c + tc;
      ts = -(fx_mul(ts, x2) / ((2 * k) * (2 * k + 1)));
      s  = s + ts;
    end
  endfunction

  function automatic int q27_ratio(input longint num, input longint den);
    logic [63:0] un;
    logic [63:0] ud;
    logic [63:0] q;
    if (den == 0) return 0;
    un = (num < 0) ? 64'(-num) : 64'(num);
    ud = (den < 0) ? 64'(-den) : 64'(den);
    if (un > (64'd1 << 36)) un = 64'd1 << 36;
    q = ((un << 27) + (ud >> 1)) / ud;
    if ((num < 0) != (den < 0))
      return (q > 64'h8000_0000) ? 32'h8000_0000 : int'(64'd0 - q);
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : int'(q);
  endfunction

  function automatic void put_entry(input int band, input int i, input longint b0,
                                    input longint b1, input longint b2, input longint a0,
                                    input longint a1, input longint a2);
    band_table[band][i][0] = q27_ratio(b0, a0);
    band_table[band][i][1] = q27_ratio(b1, a0);
    band_table[band][i][2] = q27_ratio(b2, a0);
    band_table[band][i][3] = q27_ratio(-a1, a0);
    band_table[band][i][4] = q27_ratio(-a2, a0);
  endfunction

  function automatic void build_band_table();
    longint cl, sl, cm, sm, ch, sh;
    longint db, x, ga, gr, gi, ap1, am1, al, tra, mc, pc, aa, aia;
    fx_trig(TWOPI_Q * 300 / 48000, cl, sl);
    fx_trig(TWOPI_Q * 1000 / 48000, cm, sm);
    fx_trig(TWOPI_Q * 4000 / 48000, ch, sh);
    for (int i = 0; i <= NSTEPS; i++) begin
      db  = (longint'(92 * i - 80 * NSTEPS) * ONE_Q32) / NSTEPS;
      x   = fx_mul(db, LN10_Q) / 40;
      ga  = fx_exp(x);
      gr  = fx_exp(x / 2);
      gi  = fx_exp(-x);
      ap1 = ga + ONE_Q32;
      am1 = ga - ONE_Q32;
      al  = fx_mul(sl, RSQRT2_Q);
      tra = 2 * fx_mul(gr, al);
      mc  = fx_mul(am1, cl);
      pc  = fx_mul(ap1, cl);
      put_entry(0, i, fx_mul(ga, ap1 - mc + tra), 2 * fx_mul(ga, am1 - pc),
                fx_mul(ga, ap1 - mc - tra), ap1 + mc + tra, -2 * (am1 + pc), ap1 + mc - tra);
      al  = (sm * 5) / 8;
      aa  = fx_mul(al, ga);
      aia = fx_mul(al, gi);
      put_entry(1, i, ONE_Q32 + aa, -2 * cm, ONE_Q32 - aa, ONE_Q32 + aia, -2 * cm,
                ONE_Q32 - aia);
      al  = fx_mul(sh, RSQRT2_Q);
      tra = 2 * fx_mul(gr, al);
      mc  = fx_mul(am1, ch);
      pc  = fx_mul(ap1, ch);
      put_entry(2, i, fx_mul(ga, ap1 + mc + tra), -2 * fx_mul(ga, am1 + pc),
                fx_mul(ga, ap1 + mc - tra), ap1 - mc + tra, 2 * (am1 - pc), ap1 - mc - tra);
    end
  endfunction

  function automatic void interp_band(input int band);
    int     g;
    longint q;
    longint idx;
    longint r;
    longint lo;
    longint hi;
    g = band_gain[band];
    if (g < -5120) g = -5120;
    if (g > 768) g = 768;
    q   = longint'(g + 5120) * NSTEPS;
    idx = q / SPAN;
    r   = q % SPAN;
    for (int k = 0; k < 5; k++) begin
      if (idx >= NSTEPS) begin
        band_coef[band][k] = band_table[band][NSTEPS][k];
      end else begin
        lo = band_table[band][idx][k];
        hi = band_table[band][idx + 1][k];
        band_coef[band][k] = int'(lo + ((hi - lo) * r) / SPAN);
      end
    end
  endfunction

  function automatic longint filter_lane(input int ch, input longint xin);
    longint x;
    longint acc;
    longint y;
    x = xin;
    for (int s = 0; s < 3; s++) begin
      acc = longint'(band_coef[s][0]) * x
          + longint'(band_coef[s][1]) * longint'(biquad_mem[ch][s][0])
          + longint'(band_coef[s][2]) * longint'(biquad_mem[ch][s][1])
          + longint'(band_coef[s][3]) * longint'(biquad_mem[ch][s][2])
          + longint'(band_coef[s][4]) * longint'(biquad_mem[ch][s][3]);
      y = (acc + (64'sd1 <<< 26)) >>> 27;
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      biquad_mem[ch][s][1] = biquad_mem[ch][s][0];
      biquad_mem[ch][s][0] = int'(x);
      biquad_mem[ch][s][3] = biquad_mem[ch][s][2];
      biquad_mem[ch][s][2] = int'(y);
      x = y;
    end
    return x;
  endfunction

  function automatic out_item_t equalize_pair(input in_item_t pair);
    out_item_t res;
    longint    l;
    longint    r;
    l = longint'(pair.left_sample);
    r = longint'(pair.right_sample);
    if (!pass_through) begin
      l = filter_lane(0, l);
      r = filter_lane(1, r);
    end
    res.left_out  = l[SAMPLE_BITS-1:0];
    res.right_out = r[SAMPLE_BITS-1:0];
    return res;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2, 3: return SAMPLE_BITS'($signed($urandom_range(0, 8191)) - 4096);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic void queue_pair(input logic [SAMPLE_BITS-1:0] l,
                                     input logic [SAMPLE_BITS-1:0] r);
    in_item_t it;
    it.left_sample  = l;
    it.right_sample = r;
    sample_q.push_back(it);
  endfunction

  task automatic drain();
    while (sample_q.size() != 0 || in_valid || filtered_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BYPASS) begin
      pass_through = val[0];
    end else begin
      band_gain[idx] = int'($signed(val));
      interp_band(idx);
    end
    repeat (2) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic set_gains(input int lg, input int mg, input int hg);
    write_reg(REG_LOW_GAIN, CFG_DATA_W'(lg));
    write_reg(REG_MID_GAIN, CFG_DATA_W'(mg));
    write_reg(REG_HIGH_GAIN, CFG_DATA_W'(hg));
  endtask

  function automatic int any_gain();
    return $urandom_range(0, 3) == 0 ? int'($signed(14'($urandom)))
                                     : $urandom_range(0, 5888) - 5120;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sender: a transfer happens when valid and ready are both high
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) filtered_q.push_back(equalize_pair(in_data));
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0 && !hold_send) begin
          next_pair = sample_q.pop_front();
          in_data  <= next_pair;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected output pair %h", out_data);
          err_count++;
        end else begin
          if (out_data.left_out !== filtered_q[0].left_out) begin
            $error("left_out expected %0d actual %0d", filtered_q[0].left_out,
                   out_data.left_out);
            err_count++;
          end
          if (out_data.right_out !== filtered_q[0].right_out) begin
            $error("right_out expected %0d actual %0d", filtered_q[0].right_out,
                   out_data.right_out);
            err_count++;
          end
          void'(filtered_q.pop_front());
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) recv_stall <= $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    err_count   = 0;
    cycle_count = 0;
    quiet       = 1'b0;
    hold_send   = 1'b0;
    build_band_table();
    foreach (biquad_mem[c, s, t]) biquad_mem[c][s][t] = 0;
    for (int b = 0; b < 3; b++) begin
      band_gain[b] = 0;
      interp_band(b);
    end
    pass_through = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    // directed: extremes, impulse, signs
    queue_pair(24'h7FFFFF, 24'h800000);
    queue_pair(24'h800000, 24'h7FFFFF);
    queue_pair(24'h000000, 24'h000000);
    queue_pair(24'hFFFFFF, 24'h000001);
    queue_pair(24'h400000, 24'h000000);
    for (int i = 0; i < 6; i++) queue_pair(24'h000000, 24'h000000);
    for (int i = 0; i < 6; i++) queue_pair(24'h7FFFFF, 24'h7FFFFF);
    for (int i = 0; i < 6; i++) queue_pair(24'h800000, 24'h800000);
    drain();

    // mid-phase hold until everything has come back
    for (int i = 0; i < 60; i++) queue_pair(pick_sample(), pick_sample());
    hold_send = 1'b1;
    while (in_valid || filtered_q.size() != 0) @(posedge clk);
    hold_send = 1'b0;
    for (int i = 0; i < 140; i++) queue_pair(pick_sample(), pick_sample());
    drain();

    for (int p = 1; p <= 7; p++) begin
      case (p)
        1: set_gains(768, 768, 768);
        2: set_gains(-5120, -5120, -5120);
        3: set_gains(8191, -8192, 769);
        4: set_gains(-5121, any_gain(), any_gain());
        5: begin
          set_gains(any_gain(), any_gain(), any_gain());
          write_reg(REG_BYPASS, {13'($urandom), 1'b1});
        end
        6: begin
          write_reg(REG_BYPASS, {13'($urandom), 1'b0});
          set_gains(any_gain(), any_gain(), any_gain());
        end
        default: begin
          set_gains(any_gain(), any_gain(), any_gain());
          quiet = 1'b1;
        end
      endcase
      for (int i = 0; i < 200; i++) queue_pair(pick_sample(), pick_sample());
      drain();
    end

    repeat (60) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tbspeq_pkg.sv
sv/tbspeq_div.sv
sv/tbspeq_dp.sv
sv/tbspeq_ctrl.sv
sv/three_band_shelf_peak_equalizer.sv
tb/sv/three_band_shelf_peak_equalizer_test.sv
